// ----- rtl/src_pkg.sv -----
// shared types and constants for the sensor response crc decoder
// no dependencies; imported by every module of the block
package src_pkg;

  localparam int FRAME_WORDS = 8;
  localparam int WORD_W      = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;

  localparam logic [7:0] CRC_INIT    = 8'hFF;
  localparam logic [7:0] CRC_POLY    = 8'h31;
  localparam logic [3:0] NONE_FAILED = 4'd8;

  localparam logic [15:0] UNSIGNED_SENTINEL = 16'hFFFF;
  localparam logic [15:0] SIGNED_SENTINEL   = 16'h7FFF;

  // words of the frame that carry the reported values
  localparam int PM25_WORD  = 1;
  localparam int HUM_WORD   = 4;
  localparam int TEMP_WORD  = 5;
  localparam int VOC_WORD   = 6;

  localparam int CAP_PM25 = 0;
  localparam int CAP_HUM  = 1;
  localparam int CAP_TEMP = 2;
  localparam int CAP_VOC  = 3;
  localparam int CAP_NUM  = 4;

  typedef enum logic [1:0] {
    PART_HIGH,
    PART_LOW,
    PART_CRC
  } part_t;

  typedef struct packed {
    logic        crc_ok;
    logic [3:0]  first_bad_word;
    logic [15:0] pm25_tenths;
    logic        pm25_valid;
    logic [15:0] humidity_hundredths;
    logic        humidity_valid;
    logic [15:0] temperature_200ths;
    logic        temperature_valid;
    logic [15:0] voc_tenths;
    logic        voc_valid;
  } src_result_t;

endpackage

// ----- rtl/src_crc8.sv -----
// one-byte update of the crc-8 (poly 0x31, msb first), unrolled over eight bits
// depends on src_pkg for the polynomial
module src_crc8 import src_pkg::*; (
  input  logic [7:0] crc_in,
  input  logic [7:0] data,
  output logic [7:0] crc_out
);

  always_comb begin
    logic [7:0] c;
    c = crc_in ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

// ----- rtl/src_frame.sv -----
// frame tracking: byte position, running crc, failure record and word captures
// depends on src_pkg and src_crc8
module src_frame import src_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  input  logic        frame_start,
  output logic        done,
  output src_result_t result
);

  part_t              part, part_next, eff_part;
  logic [WORD_W-1:0]  word, word_next, eff_word;
  logic [7:0]         running_crc, running_crc_next, eff_crc, crc_new;
  logic [7:0]         word_high_byte, word_high_byte_next;
  logic [7:0]         word_low_byte, word_low_byte_next;
  logic               fail_seen, fail_seen_next, eff_fail;
  logic [3:0]         failing_word, failing_word_next, eff_failing;
  logic [15:0]        captured_values [CAP_NUM];
  logic [15:0]        captured_values_next [CAP_NUM];
  logic [15:0]        word_value;
  logic               mismatch;

  // a frame start restarts the frame before this byte is taken
  always_comb begin
    eff_part    = frame_start ? PART_HIGH : part;
    eff_word    = frame_start ? '0 : word;
    eff_crc     = frame_start ? CRC_INIT : running_crc;
    eff_fail    = frame_start ? 1'b0 : fail_seen;
    eff_failing = frame_start ? NONE_FAILED : failing_word;
  end

  src_crc8 u_crc8 (
    .crc_in  (eff_crc),
    .data    (rx_byte),
    .crc_out (crc_new)
  );

  assign word_value = {word_high_byte, word_low_byte};
  assign mismatch   = (eff_part == PART_CRC) && (eff_crc != rx_byte);
  assign done       = (eff_part == PART_CRC) && (eff_word == WORD_W'(FRAME_WORDS - 1));

  always_comb begin
    part_next           = eff_part;
    word_next           = eff_word;
    running_crc_next    = eff_crc;
    word_high_byte_next = word_high_byte;
    word_low_byte_next  = word_low_byte;
    fail_seen_next      = eff_fail;
    failing_word_next   = eff_failing;
    for (int i = 0; i < CAP_NUM; i++) begin
      captured_values_next[i] = captured_values[i];
    end

    unique case (eff_part)
      PART_HIGH: begin
        word_high_byte_next = rx_byte;
        running_crc_next    = crc_new;
        part_next           = PART_LOW;
      end
      PART_LOW: begin
        word_low_byte_next = rx_byte;
        running_crc_next   = crc_new;
        part_next          = PART_CRC;
      end
      PART_CRC: begin
        if (mismatch && !eff_fail) begin
          fail_seen_next    = 1'b1;
          failing_word_next = 4'(eff_word);
        end
        running_crc_next = CRC_INIT;
        part_next        = PART_HIGH;
        word_next        = eff_word + 1'b1;
        if (eff_word == WORD_W'(PM25_WORD)) captured_values_next[CAP_PM25] = word_value;
        if (eff_word == WORD_W'(HUM_WORD))  captured_values_next[CAP_HUM]  = word_value;
        if (eff_word == WORD_W'(TEMP_WORD)) captured_values_next[CAP_TEMP] = word_value;
        if (eff_word == WORD_W'(VOC_WORD))  captured_values_next[CAP_VOC]  = word_value;
      end
      default: begin
        part_next = PART_HIGH;
      end
    endcase

    // end of frame: back to the start for the next item
    if (done) begin
      part_next         = PART_HIGH;
      word_next         = '0;
      running_crc_next  = CRC_INIT;
      fail_seen_next    = 1'b0;
      failing_word_next = NONE_FAILED;
    end
  end

  // result built from the updated captures so a capture on the last word is seen
  always_comb begin
    logic pv, hv, tv, vv;
    pv = captured_values_next[CAP_PM25] != UNSIGNED_SENTINEL;
    hv = captured_values_next[CAP_HUM]  != SIGNED_SENTINEL;
    tv = captured_values_next[CAP_TEMP] != SIGNED_SENTINEL;
    vv = captured_values_next[CAP_VOC]  != SIGNED_SENTINEL;
    result.crc_ok              = !(eff_fail || mismatch);
    result.first_bad_word      = eff_fail ? eff_failing :
                                 (mismatch ? 4'(eff_word) : NONE_FAILED);
    result.pm25_tenths         = pv ? captured_values_next[CAP_PM25] : 16'd0;
    result.pm25_valid          = pv;
    result.humidity_hundredths = hv ? captured_values_next[CAP_HUM] : 16'd0;
    result.humidity_valid      = hv;
    result.temperature_200ths  = tv ? captured_values_next[CAP_TEMP] : 16'd0;
    result.temperature_valid   = tv;
    result.voc_tenths          = vv ? captured_values_next[CAP_VOC] : 16'd0;
    result.voc_valid           = vv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      part         <= PART_HIGH;
      word         <= '0;
      running_crc  <= CRC_INIT;
      fail_seen    <= 1'b0;
      failing_word <= NONE_FAILED;
    end else if (step) begin
      part         <= part_next;
      word         <= word_next;
      running_crc  <= running_crc_next;
      fail_seen    <= fail_seen_next;
      failing_word <= failing_word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      word_high_byte <= word_high_byte_next;
      word_low_byte  <= word_low_byte_next;
      for (int i = 0; i < CAP_NUM; i++) begin
        captured_values[i] <= captured_values_next[i];
      end
    end
  end

endmodule

// ----- rtl/sensor_response_crc_decoder.sv -----
// Sensor response frame checker and decoder.
// Input channel (in_valid / in_stall): one response byte per item, rx_byte,
// with frame_start high on the first byte of a frame. A frame is eight
// words of high byte, low byte and crc-8 byte (poly 0x31, init 0xFF).
// Output channel (out_valid / out_stall): one item per complete frame,
// on its last byte, with crc status, the first failing word (8 if none)
// and the four decoded values, each with a valid flag that drops to 0
// (value forced to 0) on the sensor's sentinel code.
// A frame start in the middle of a frame drops the partial frame.
// Throughput: one byte per cycle while the receiver does not stall; the crc
// update is eight unrolled steps between the input register and the result
// register. A frame's result shows once its last byte has passed both registers.
// Reset (rst, synchronous) empties both registers and restarts the frame.
// When the receiver stalls, the result register holds; the input register
// still takes a byte if empty, then in_stall goes high until the result is taken.
// depends on src_pkg, src_frame
module sensor_response_crc_decoder import src_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  input  logic               frame_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               crc_ok,
  output logic [3:0]         first_bad_word,
  output logic [15:0]        pm25_tenths,
  output logic               pm25_valid,
  output logic signed [15:0] humidity_hundredths,
  output logic               humidity_valid,
  output logic signed [15:0] temperature_200ths,
  output logic               temperature_valid,
  output logic signed [15:0] voc_tenths,
  output logic               voc_valid
);

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_start;
  logic        advance;
  logic        step;
  logic        done;
  src_result_t result;
  src_result_t out_reg;

  // the pipeline moves whenever the result register is free or being emptied
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign step     = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte  <= rx_byte;
      s1_start <= frame_start;
    end
  end

  src_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .rx_byte     (s1_byte),
    .frame_start (s1_start),
    .done        (done),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && done;
    end
  end

  always_ff @(posedge clk) begin
    if (step && done) begin
      out_reg <= result;
    end
  end

  assign crc_ok              = out_reg.crc_ok;
  assign first_bad_word      = out_reg.first_bad_word;
  assign pm25_tenths         = out_reg.pm25_tenths;
  assign pm25_valid          = out_reg.pm25_valid;
  assign humidity_hundredths = out_reg.humidity_hundredths;
  assign humidity_valid      = out_reg.humidity_valid;
  assign temperature_200ths  = out_reg.temperature_200ths;
  assign temperature_valid   = out_reg.temperature_valid;
  assign voc_tenths          = out_reg.voc_tenths;
  assign voc_valid           = out_reg.voc_valid;

endmodule
